FILE: design/pct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants for the prefetch congestion throttle
// Field widths, opcodes, register map, controller states and the control
// structs passed between the controller and the latency averaging unit.
// ----------------------------------------------------------------------------
package pct_pkg;

    // Defaults for the top-level parameters
    localparam int STATS_ENTRIES_DEF = 256;   // must be a power of two
    localparam int MODE_PERIOD_DEF   = 1024;
    localparam int COUNT_WIDTH_DEF   = 16;

    // Fixed field widths
    localparam int PC_WIDTH   = 64;
    localparam int LAT_WIDTH  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int AVG_WIDTH  = LAT_WIDTH + FRAC_BITS;   // Q16.8
    localparam int THR_WIDTH  = 16;
    localparam int ACC_WIDTH  = 9;
    localparam int MIN_WIDTH  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;

    // Register reset values
    localparam logic [THR_WIDTH-1:0] LAT_HIGH_RST = THR_WIDTH'(400);
    localparam logic [THR_WIDTH-1:0] LAT_LOW_RST  = THR_WIDTH'(300);
    localparam logic [ACC_WIDTH-1:0] ACC_RST      = ACC_WIDTH'(128);
    localparam logic [MIN_WIDTH-1:0] MIN_ISS_RST  = MIN_WIDTH'(16);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ISSUE  = 2'd1,
        OP_USEFUL = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_LAT_HIGH = 2'd0,
        REG_LAT_LOW  = 2'd1,
        REG_ACCURACY = 2'd2,
        REG_MIN_ISS  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_FIN   = 2'd2,
        ST_SWEEP = 2'd3
    } state_t;

    typedef struct packed {
        logic calc;     // form the sample difference
        logic commit;   // update average, phase and mode
    } avg_ctl_t;

    typedef struct packed {
        logic mode;       // current mode
        logic mode_next;  // mode after the pending sample
        logic switched;   // pending sample flips the mode
        logic wrap;       // pending sample closes a period
    } avg_stat_t;

endpackage
`default_nettype wire

FILE: design/pct_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_ram: per-PC statistics table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pct_ram
    import pct_pkg::*;
#(
    parameter int DEPTH = STATS_ENTRIES_DEF,
    parameter int WIDTH = PC_WIDTH + 2 * COUNT_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/pct_avg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_avg: fill latency moving average and conservative mode
// Q16.8 average with weight 1/256, period counter and hysteresis compare.
// ----------------------------------------------------------------------------
module pct_avg
    import pct_pkg::*;
#(
    parameter int MODE_PERIOD = MODE_PERIOD_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire avg_ctl_t             ctl,
    input  wire logic [LAT_WIDTH-1:0] sample,
    input  wire logic [THR_WIDTH-1:0] latency_high,
    input  wire logic [THR_WIDTH-1:0] latency_low,
    output avg_stat_t                 stat
);

    localparam int PHASE_WIDTH = $clog2(MODE_PERIOD);
    localparam logic [PHASE_WIDTH-1:0] PHASE_LAST = PHASE_WIDTH'(MODE_PERIOD - 1);

    logic [AVG_WIDTH-1:0]   avg_reg;
    logic [AVG_WIDTH-1:0]   avg_next;
    logic                   seen_reg;
    logic                   mode_reg;
    logic                   mode_next;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] phase_next;
    logic signed [AVG_WIDTH:0] diff_reg;
    logic signed [AVG_WIDTH:0] diff_next;
    logic signed [AVG_WIDTH:0] step;
    logic signed [AVG_WIDTH:0] sum;
    logic [AVG_WIDTH-1:0]   target;
    logic [AVG_WIDTH-1:0]   hi_thr;
    logic [AVG_WIDTH-1:0]   lo_thr;
    logic                   wrap;

    assign target    = {sample, {FRAC_BITS{1'b0}}};
    assign hi_thr    = {latency_high, {FRAC_BITS{1'b0}}};
    assign lo_thr    = {latency_low, {FRAC_BITS{1'b0}}};
    assign diff_next = $signed({1'b0, target}) - $signed({1'b0, avg_reg});

    // floor of the difference over 256, both directions
    assign step     = diff_reg >>> FRAC_BITS;
    assign sum      = $signed({1'b0, avg_reg}) + step;
    assign avg_next = seen_reg ? sum[AVG_WIDTH-1:0] : target;

    assign wrap       = (phase_reg == PHASE_LAST);
    assign phase_next = wrap ? '0 : phase_reg + PHASE_WIDTH'(1);

    always_comb
    begin
        mode_next = mode_reg;
        if (wrap)
        begin
            if (!mode_reg && (avg_next > hi_thr))
            begin
                mode_next = 1'b1;
            end
            else if (mode_reg && (avg_next < lo_thr))
            begin
                mode_next = 1'b0;
            end
        end
    end

    assign stat.mode      = mode_reg;
    assign stat.mode_next = mode_next;
    assign stat.switched  = (mode_next != mode_reg);
    assign stat.wrap      = wrap;

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            diff_reg <= diff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg   <= '0;
            seen_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else if (ctl.commit)
        begin
            avg_reg   <= avg_next;
            seen_reg  <= 1'b1;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/prefetch_congestion_throttle_unit.sv
// An accepted item passes through the execute and finish states; its result
// is registered in the finish state once the output is free. Items are taken
// one at a time: the next item is accepted in the finish state of the last.
// A sample that closes a mode period starts a decay sweep that halves the
// counters of every slot of the table RAM, with in_ready low.
// Reset clears all control state and the valid bits; no clearing pass is run.
`default_nettype none
// ----------------------------------------------------------------------------
// prefetch_congestion_throttle_unit: feedback-directed prefetch throttle
// Moving average of fill latency drives a conservative mode; a direct-mapped
// per-PC table of issued/useful counts answers gate queries.
// ----------------------------------------------------------------------------
module prefetch_congestion_throttle_unit
    import pct_pkg::*;
#(
    parameter int STATS_ENTRIES = STATS_ENTRIES_DEF,
    parameter int MODE_PERIOD   = MODE_PERIOD_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [DATA_WIDTH-1:0] pwdata,
    output logic      [DATA_WIDTH-1:0] prdata,
    output logic                       pready,
    // items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            op,
    input  wire logic [PC_WIDTH-1:0]   pc,
    input  wire logic [LAT_WIDTH-1:0]  latency,
    // results
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       conservative,
    output logic                       gated,
    output logic                       mode_switched
);

    localparam int IDX_W   = $clog2(STATS_ENTRIES);
    localparam int ENT_W   = PC_WIDTH + 2 * COUNT_WIDTH;
    localparam int PROD_W  = ACC_WIDTH + COUNT_WIDTH;
    localparam int CMP_W   = (COUNT_WIDTH > MIN_WIDTH) ? COUNT_WIDTH : MIN_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_W:0] SWEEP_END = (IDX_W + 1)'(STATS_ENTRIES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_WIDTH-1:0] lat_high_reg;
    logic [THR_WIDTH-1:0] lat_low_reg;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [MIN_WIDTH-1:0] min_iss_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_high_reg <= LAT_HIGH_RST;
            lat_low_reg  <= LAT_LOW_RST;
            acc_reg      <= ACC_RST;
            min_iss_reg  <= MIN_ISS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_LAT_HIGH: lat_high_reg <= pwdata[THR_WIDTH-1:0];
                REG_LAT_LOW:  lat_low_reg  <= pwdata[THR_WIDTH-1:0];
                REG_ACCURACY: acc_reg      <= pwdata[ACC_WIDTH-1:0];
                REG_MIN_ISS:  min_iss_reg  <= pwdata[MIN_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_LAT_HIGH: prdata = DATA_WIDTH'(lat_high_reg);
            REG_LAT_LOW:  prdata = DATA_WIDTH'(lat_low_reg);
            REG_ACCURACY: prdata = DATA_WIDTH'(acc_reg);
            REG_MIN_ISS:  prdata = DATA_WIDTH'(min_iss_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    state_t               state_reg;
    state_t               state_next;
    logic                 in_fire;
    logic                 out_free;
    logic                 fin_sweep;
    logic                 out_load;

    logic [1:0]           op_reg;
    logic [PC_WIDTH-1:0]  pc_reg;
    logic [LAT_WIDTH-1:0] lat_reg;
    op_t                  cur_op;

    logic [IDX_W:0]       sweep_cnt_reg;
    logic [STATS_ENTRIES-1:0] valid_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    avg_ctl_t             avg_ctl;
    avg_stat_t            avg_stat;

    logic                 out_valid_reg;
    logic                 cons_reg;
    logic                 gated_reg;
    logic                 switched_reg;

    assign cur_op    = op_t'(op_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign fin_sweep = (cur_op == OP_SAMPLE) && avg_stat.wrap;
    assign in_ready  = (state_reg == ST_IDLE) ||
                       ((state_reg == ST_FIN) && out_free && !fin_sweep);
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op;
            pc_reg  <= pc;
            lat_reg <= latency;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (fin_sweep)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (in_fire)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == SWEEP_END)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Table access
    // ------------------------------------------------------------------
    logic [PC_WIDTH-1:0]    rd_tag;
    logic [COUNT_WIDTH-1:0] rd_iss;
    logic [COUNT_WIDTH-1:0] rd_use;
    logic [IDX_W-1:0]       cur_idx;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] base_iss;
    logic [COUNT_WIDTH-1:0] base_use;
    logic [COUNT_WIDTH-1:0] new_iss;
    logic [COUNT_WIDTH-1:0] new_use;

    assign {rd_tag, rd_iss, rd_use} = ram_rdata;
    assign cur_idx  = pc_reg[IDX_W-1:0];
    assign hit      = valid_reg[cur_idx] && (rd_tag == pc_reg);
    // a miss reallocates the slot with cleared counters
    assign base_iss = hit ? rd_iss : '0;
    assign base_use = hit ? rd_use : '0;
    assign new_iss  = (cur_op == OP_ISSUE) && (base_iss != CNT_MAX) ?
                      base_iss + COUNT_WIDTH'(1) : base_iss;
    assign new_use  = (cur_op == OP_USEFUL) && (base_use != CNT_MAX) ?
                      base_use + COUNT_WIDTH'(1) : base_use;

    // outputs of the controller
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = cur_idx;
        ram_wdata      = {pc_reg, new_iss, new_use};
        ram_raddr      = pc[IDX_W-1:0];
        avg_ctl.calc   = 1'b0;
        avg_ctl.commit = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                ram_we       = (cur_op == OP_ISSUE) || (cur_op == OP_USEFUL);
                avg_ctl.calc = (cur_op == OP_SAMPLE);
            end
            ST_FIN:
            begin
                out_load       = out_free;
                avg_ctl.commit = out_free && (cur_op == OP_SAMPLE);
            end
            ST_SWEEP:
            begin
                // read slot n while writing back slot n-1 halved
                ram_raddr = sweep_cnt_reg[IDX_W-1:0];
                ram_we    = (sweep_cnt_reg != '0);
                ram_waddr = sweep_cnt_reg[IDX_W-1:0] - IDX_W'(1);
                ram_wdata = {rd_tag, rd_iss >> 1, rd_use >> 1};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (state_reg == ST_SWEEP)
        begin
            sweep_cnt_reg <= (sweep_cnt_reg == SWEEP_END) ? '0
                                                          : sweep_cnt_reg + (IDX_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if ((state_reg == ST_EXEC) && ram_we)
        begin
            valid_reg[cur_idx] <= 1'b1;
        end
    end

    pct_ram #(
        .DEPTH (STATS_ENTRIES),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Gate query: registered lookup, then multiply and compare
    // ------------------------------------------------------------------
    logic                   hit_reg;
    logic [COUNT_WIDTH-1:0] iss_reg;
    logic [COUNT_WIDTH-1:0] use_reg;
    logic [PROD_W-1:0]      need;
    logic [PROD_W-1:0]      have;
    logic                   gate;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            hit_reg <= hit;
            iss_reg <= rd_iss;
            use_reg <= rd_use;
        end
    end

    assign need = PROD_W'(acc_reg) * PROD_W'(iss_reg);
    assign have = PROD_W'({use_reg, {FRAC_BITS{1'b0}}});
    assign gate = hit_reg && (CMP_W'(iss_reg) >= CMP_W'(min_iss_reg)) && (have < need);

    // ------------------------------------------------------------------
    // Latency average and mode
    // ------------------------------------------------------------------
    pct_avg #(
        .MODE_PERIOD (MODE_PERIOD)
    ) u_avg (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (avg_ctl),
        .sample       (lat_reg),
        .latency_high (lat_high_reg),
        .latency_low  (lat_low_reg),
        .stat         (avg_stat)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cons_reg     <= (cur_op == OP_SAMPLE) ? avg_stat.mode_next : avg_stat.mode;
            gated_reg    <= (cur_op == OP_QUERY) && gate;
            switched_reg <= (cur_op == OP_SAMPLE) && avg_stat.switched;
        end
    end

    assign out_valid     = out_valid_reg;
    assign conservative  = cons_reg;
    assign gated         = gated_reg;
    assign mode_switched = switched_reg;

endmodule
`default_nettype wire

FILE: design/pct_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_checker: port-level checks for the prefetch congestion throttle
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module pct_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pready,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic conservative,
    input wire logic gated,
    input wire logic mode_switched
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(conservative) && $stable(gated) && $stable(mode_switched))
        else $error("result beat changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item executes");

    // only a sample may switch mode and only a query may gate, so no beat shows both
    a_gate_vs_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(gated && mode_switched))
        else $error("beat reports both a gate answer and a mode switch");

    // a mode switch shows the new mode differing from the previous beat's mode
    a_switch_flips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && mode_switched |->
            conservative != $past(conservative))
        else $error("mode switch without a mode change");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind prefetch_congestion_throttle_unit pct_checker u_pct_checker (.*);
`default_nettype wire
